// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ccr_pkg.sv =====
// Types, constants and rounding helper for the Catmull-Rom evaluator.
// No dependencies.
`timescale 1ns / 1ps
package ccr_pkg;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_EVAL  = 1'b1
   } func_type;

   localparam int CNT_W   = 7;
   localparam int IDX_W   = 6;
   localparam int T_W     = 16;
   localparam int MIN_CNT = 4;

   localparam int WGT_W  = 56;
   localparam int PROD_W = 64;
   localparam int PAIR_W = 65;
   localparam int SUM_W  = 66;
   localparam int RND_W  = 36;

   localparam logic signed [WGT_W-1:0] WGT_ONE  = 56'sd562949953421312;  // 2^49
   localparam logic signed [WGT_W-1:0] WGT_HALF = 56'sd281474976710656;  // 2^48
   localparam logic signed [WGT_W-1:0] WGT_RND  = 56'sd262144;           // 2^18
   localparam logic signed [SUM_W-1:0] SUM_RND  = 66'sd536870912;        // 2^29

   localparam logic signed [RND_W-1:0] SAT_HI = 36'sd2147483647;
   localparam logic signed [RND_W-1:0] SAT_LO = -36'sd2147483648;

   // scale 2^49 down to Q2.30, halves toward plus infinity
   function automatic coord_type round_weight(input logic signed [WGT_W-1:0] v);
      logic signed [WGT_W-1:0] r;
      r = (v + WGT_RND) >>> 19;
      return signed'(r[31:0]);
   endfunction

endpackage

// ===== rtl/closed_catmull_rom_evaluator.sv =====
// Closed uniform Catmull-Rom curve evaluator, top level.
// Depends on ccr_pkg, ccr_axis and assert_macros.svh.
//
//   port group  direction  carries
//   req_*       in         point write or curve evaluation request
//   rsp_*       out        position, slope and clip flag per evaluation
//   csr_*       in         point count register write
//
// One request enters per cycle while no held response stalls the pipeline.
// The slot read, the weight multiplies and the 32x32 blend multiplies set the
// stage boundaries. A held response stalls the whole pipeline in place.
// Reset clears the pipeline valids and sets the point count to 4; the point
// store holds no reset value and needs no clearing.
`timescale 1ns / 1ps
module closed_catmull_rom_evaluator #(
   parameter int MAX_POINTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [ccr_pkg::IDX_W-1:0]    req_point_index,
   input  ccr_pkg::coord_type           req_coord_x,
   input  ccr_pkg::coord_type           req_coord_y,
   input  ccr_pkg::coord_type           req_coord_z,
   input  logic [ccr_pkg::T_W-1:0]      req_eval_t,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ccr_pkg::coord_type           rsp_pos_x,
   output ccr_pkg::coord_type           rsp_pos_y,
   output ccr_pkg::coord_type           rsp_pos_z,
   output ccr_pkg::coord_type           rsp_slope_x,
   output ccr_pkg::coord_type           rsp_slope_y,
   output ccr_pkg::coord_type           rsp_slope_z,
   output logic                         rsp_clipped,
   input  logic                         csr_wr_en,
   input  logic [ccr_pkg::CNT_W-1:0]    csr_wr_data
);
   import ccr_pkg::*;
   `include "assert_macros.svh"

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int SW = T_W + NW;

   logic              en;
   logic [CNT_W-1:0]  count_ff;
   logic [NW-1:0]     n_in;
   logic [SW-1:0]     s_in;

   logic              v1_ff, f1_ff, wok1_ff;
   logic [AW-1:0]     widx1_ff, seg1_ff;
   point_type         wpt1_ff;
   logic [T_W-1:0]    u1_ff;
   logic [AW-1:0]     ra_in [4];
   logic [NW:0]       nx1_in, nx2_in;

   logic              v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic [T_W-1:0]    u2_ff, u3_ff;
   logic [31:0]       uu2_ff, uu3_ff;
   logic [47:0]       uuu3_ff;
   point_type         pts2_ff [4];
   point_type         pts3_ff [4];
   point_type         pts4_ff [4];
   point_type         bank_ff [4][MAX_POINTS];
   coord_type         w4_ff [4];
   coord_type         d4_ff [4];
   coord_type         w_in [4];
   coord_type         d_in [4];
   coord_type         px [4];
   coord_type         py [4];
   coord_type         pz [4];
   logic              clip_x, clip_y, clip_z;

   assign en        = !(v8_ff && rsp_stall);
   assign req_stall = v8_ff && rsp_stall;
   assign rsp_valid = v8_ff;
   assign rsp_clipped = clip_x | clip_y | clip_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(MIN_CNT);
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // clamp the point count and split the scaled parameter
   always_comb begin
      priority if (32'(count_ff) < MIN_CNT) begin
         n_in = NW'(MIN_CNT);
      end else if (32'(count_ff) > MAX_POINTS) begin
         n_in = NW'(MAX_POINTS);
      end else begin
         n_in = NW'(count_ff);
      end
      s_in = SW'(req_eval_t) * SW'(n_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff && (f1_ff == FUNC_EVAL);
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= req_func;
         wok1_ff  <= 32'(req_point_index) < MAX_POINTS;
         widx1_ff <= AW'(32'(req_point_index));
         wpt1_ff  <= '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
         seg1_ff  <= AW'(s_in[SW-1:T_W]);
         u1_ff    <= s_in[T_W-1:0];
      end
   end

   // neighbor slots modulo the count
   always_comb begin
      nx1_in = (NW+1)'(seg1_ff) + (NW+1)'(1);
      nx2_in = (NW+1)'(seg1_ff) + (NW+1)'(2);
      if (nx1_in >= (NW+1)'(n_in)) begin
         nx1_in = nx1_in - (NW+1)'(n_in);
      end
      if (nx2_in >= (NW+1)'(n_in)) begin
         nx2_in = nx2_in - (NW+1)'(n_in);
      end
      if (seg1_ff == '0) begin
         ra_in[0] = AW'(n_in - NW'(1));
      end else begin
         ra_in[0] = seg1_ff - AW'(1);
      end
      ra_in[1] = seg1_ff;
      ra_in[2] = AW'(nx1_in);
      ra_in[3] = AW'(nx2_in);
   end

   // one copy of the store per read port, all written together
   for (genvar b = 0; b < 4; b++) begin : g_bank
      always_ff @(posedge clock) begin
         if (en) begin
            if (v1_ff && (f1_ff == FUNC_WRITE) && wok1_ff) begin
               bank_ff[b][widx1_ff] <= wpt1_ff;
            end
            pts2_ff[b] <= bank_ff[b][ra_in[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u2_ff   <= u1_ff;
         uu2_ff  <= 32'(u1_ff) * 32'(u1_ff);
         u3_ff   <= u2_ff;
         uu3_ff  <= uu2_ff;
         uuu3_ff <= 48'(uu2_ff) * 48'(u2_ff);
         pts3_ff <= pts2_ff;
         pts4_ff <= pts3_ff;
         w4_ff   <= w_in;
         d4_ff   <= d_in;
      end
   end

   // basis weights at scale 2^49, then Q2.30
   always_comb begin
      logic signed [WGT_W-1:0] a1, a2, a3;
      a1 = signed'(WGT_W'(u3_ff));
      a2 = signed'(WGT_W'(uu3_ff));
      a3 = signed'(WGT_W'(uuu3_ff));
      w_in[0] = round_weight(-a3 + (a2 <<< 17) - (a1 <<< 32));
      w_in[1] = round_weight(3 * a3 - 5 * (a2 <<< 16) + WGT_ONE);
      w_in[2] = round_weight(-3 * a3 + (a2 <<< 18) + (a1 <<< 32));
      w_in[3] = round_weight(a3 - (a2 <<< 16));
      d_in[0] = round_weight(-3 * (a2 <<< 16) + (a1 <<< 34) - WGT_HALF);
      d_in[1] = round_weight(9 * (a2 <<< 16) - 5 * (a1 <<< 33));
      d_in[2] = round_weight(-9 * (a2 <<< 16) + (a1 <<< 35) + WGT_HALF);
      d_in[3] = round_weight(3 * (a2 <<< 16) - (a1 <<< 33));
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px[k] = pts4_ff[k].x;
         py[k] = pts4_ff[k].y;
         pz[k] = pts4_ff[k].z;
      end
   end

   ccr_axis u_axis_x (
      .clock(clock), .en(en), .w_i(w4_ff), .d_i(d4_ff), .p_i(px),
      .pos_o(rsp_pos_x), .slope_o(rsp_slope_x), .clip_o(clip_x)
   );

   ccr_axis u_axis_y (
      .clock(clock), .en(en), .w_i(w4_ff), .d_i(d4_ff), .p_i(py),
      .pos_o(rsp_pos_y), .slope_o(rsp_slope_y), .clip_o(clip_y)
   );

   ccr_axis u_axis_z (
      .clock(clock), .en(en), .w_i(w4_ff), .d_i(d4_ff), .p_i(pz),
      .pos_o(rsp_pos_z), .slope_o(rsp_slope_z), .clip_o(clip_z)
   );

   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")
   `ASSERT_CLK(a_drain, v7_ff && !req_stall |=> rsp_valid, "pipeline lost a request")
   `ASSERT_CLK(a_clip_limit, rsp_valid && rsp_clipped |-> rsp_pos_x[30:0] == 31'h7FFFFFFF || rsp_pos_x[30:0] == 31'h0 || rsp_pos_y[30:0] == 31'h7FFFFFFF || rsp_pos_y[30:0] == 31'h0 || rsp_pos_z[30:0] == 31'h7FFFFFFF || rsp_pos_z[30:0] == 31'h0 || rsp_slope_x[30:0] == 31'h7FFFFFFF || rsp_slope_x[30:0] == 31'h0 || rsp_slope_y[30:0] == 31'h7FFFFFFF || rsp_slope_y[30:0] == 31'h0 || rsp_slope_z[30:0] == 31'h7FFFFFFF || rsp_slope_z[30:0] == 31'h0, "clip flag without a saturated value")

endmodule

// ===== rtl/ccr_axis.sv =====
// One coordinate axis: blend four points with position and slope weights,
// round to Q16.16 and saturate. Depends on ccr_pkg.
`timescale 1ns / 1ps
module ccr_axis (
   input  logic               clock,
   input  logic               en,
   input  ccr_pkg::coord_type w_i [4],
   input  ccr_pkg::coord_type d_i [4],
   input  ccr_pkg::coord_type p_i [4],
   output ccr_pkg::coord_type pos_o,
   output ccr_pkg::coord_type slope_o,
   output logic               clip_o
);
   import ccr_pkg::*;

   logic signed [PROD_W-1:0] wp_ff [4];
   logic signed [PROD_W-1:0] dp_ff [4];
   logic signed [PAIR_W-1:0] wpa_ff, wpb_ff, dpa_ff, dpb_ff;
   logic signed [RND_W-1:0]  wr_ff, dr_ff;
   logic signed [SUM_W-1:0]  wsum_in, dsum_in, wsh_in, dsh_in;
   coord_type                pos_ff, slope_ff;
   logic                     pclip_ff, sclip_ff;
   coord_type                pos_in, slope_in;
   logic                     pclip_in, sclip_in;

   always_comb begin
      wsum_in = SUM_W'(wpa_ff) + SUM_W'(wpb_ff) + SUM_RND;
      dsum_in = SUM_W'(dpa_ff) + SUM_W'(dpb_ff) + SUM_RND;
      wsh_in  = wsum_in >>> 30;
      dsh_in  = dsum_in >>> 30;
   end

   always_comb begin
      pclip_in = 1'b1;
      sclip_in = 1'b1;
      priority if (wr_ff > SAT_HI) begin
         pos_in = SAT_HI[31:0];
      end else if (wr_ff < SAT_LO) begin
         pos_in = SAT_LO[31:0];
      end else begin
         pos_in   = wr_ff[31:0];
         pclip_in = 1'b0;
      end
      priority if (dr_ff > SAT_HI) begin
         slope_in = SAT_HI[31:0];
      end else if (dr_ff < SAT_LO) begin
         slope_in = SAT_LO[31:0];
      end else begin
         slope_in = dr_ff[31:0];
         sclip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            wp_ff[k] <= w_i[k] * p_i[k];
            dp_ff[k] <= d_i[k] * p_i[k];
         end
         wpa_ff   <= PAIR_W'(wp_ff[0]) + PAIR_W'(wp_ff[1]);
         wpb_ff   <= PAIR_W'(wp_ff[2]) + PAIR_W'(wp_ff[3]);
         dpa_ff   <= PAIR_W'(dp_ff[0]) + PAIR_W'(dp_ff[1]);
         dpb_ff   <= PAIR_W'(dp_ff[2]) + PAIR_W'(dp_ff[3]);
         wr_ff    <= wsh_in[RND_W-1:0];
         dr_ff    <= dsh_in[RND_W-1:0];
         pos_ff   <= pos_in;
         slope_ff <= slope_in;
         pclip_ff <= pclip_in;
         sclip_ff <= sclip_in;
      end
   end

   assign pos_o   = pos_ff;
   assign slope_o = slope_ff;
   assign clip_o  = pclip_ff | sclip_ff;

endmodule

// ===== dv/closed_catmull_rom_evaluator_test.sv =====
// Self-checking testbench for closed_catmull_rom_evaluator: point loads, curve evaluations
// and point count settings, checked against an in-bench fixed point predictor.
// Depends on ccr_pkg and the evaluator RTL.
`timescale 1ns / 1ps
module closed_catmull_rom_evaluator_test;
   import ccr_pkg::*;

   typedef logic signed [79:0] wide_type;

   typedef struct {
      coord_type pos_x, pos_y, pos_z, slope_x, slope_y, slope_z;
      logic      clipped;
   } curve_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = 1'b0;
   logic [IDX_W-1:0] req_point_index = '0;
   coord_type req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic [T_W-1:0] req_eval_t = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   coord_type rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_slope_x, rsp_slope_y, rsp_slope_z;
   logic rsp_clipped;
   logic csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   point_type point_store [64];
   logic [CNT_W-1:0] point_count = 7'd4;
   curve_type pending_curves [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_start = 1'b0;
   int hold_cycles = 0;
   int stuck_cycles = 0;
   int error_count = 0;

   always #5 clock = ~clock;

   closed_catmull_rom_evaluator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_point_index(req_point_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z), .req_eval_t(req_eval_t),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_slope_x(rsp_slope_x), .rsp_slope_y(rsp_slope_y), .rsp_slope_z(rsp_slope_z),
      .rsp_clipped(rsp_clipped), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   function automatic wide_type round_down(input wide_type v, input int sh);
      return (v + (wide_type'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic coord_type saturate(input wide_type v, inout logic clip);
      if (v > wide_type'(32'sh7fffffff)) begin
         clip = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -wide_type'(64'sh80000000)) begin
         clip = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic curve_type blend_curve(input logic [T_W-1:0] g);
      int unsigned n, s, seg;
      wide_type u, u2, u3, ps, ds, p;
      wide_type w [4];
      wide_type d [4];
      coord_type r [6];
      point_type pt;
      logic clip;
      curve_type c;
      n = point_count;
      if (n < 4) n = 4;
      if (n > 64) n = 64;
      s = g * n;
      seg = s >> 16;
      u = s & 32'hffff;
      u2 = u * u;
      u3 = u2 * u;
      w[0] = -u3 + (u2 <<< 17) - (u <<< 32);
      w[1] = 3 * u3 - 5 * (u2 <<< 16) + (wide_type'(1) <<< 49);
      w[2] = -3 * u3 + (u2 <<< 18) + (u <<< 32);
      w[3] = u3 - (u2 <<< 16);
      d[0] = -3 * (u2 <<< 16) + (u <<< 34) - (wide_type'(1) <<< 48);
      d[1] = 9 * (u2 <<< 16) - 5 * (u <<< 33);
      d[2] = -9 * (u2 <<< 16) + (u <<< 35) + (wide_type'(1) <<< 48);
      d[3] = 3 * (u2 <<< 16) - (u <<< 33);
      for (int k = 0; k < 4; k++) begin
         w[k] = round_down(w[k], 19);
         d[k] = round_down(d[k], 19);
      end
      clip = 1'b0;
      for (int a = 0; a < 3; a++) begin
         ps = 0;
         ds = 0;
         for (int k = 0; k < 4; k++) begin
            pt = point_store[(seg + n - 1 + k) % n];
            p = (a == 0) ? pt.x : (a == 1) ? pt.y : pt.z;
            ps += w[k] * p;
            ds += d[k] * p;
         end
         r[a] = saturate(round_down(ps, 30), clip);
         r[3 + a] = saturate(round_down(ds, 30), clip);
      end
      c.pos_x = r[0]; c.pos_y = r[1]; c.pos_z = r[2];
      c.slope_x = r[3]; c.slope_y = r[4]; c.slope_z = r[5];
      c.clipped = clip;
      return c;
   endfunction

   // receiver side: random stall, long hold-off once requested
   always @(posedge clock) begin
      if (hold_start && hold_cycles < 200) begin
         hold_cycles <= hold_cycles + 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // stall and valid change only at rising edges, so the falling edge sees the deciding values
   always @(negedge clock) begin
      curve_type c;
      if (!reset) begin
         stuck_cycles++;
         if (req_valid && !req_stall) stuck_cycles = 0;
         if (rsp_valid && !rsp_stall) begin
            stuck_cycles = 0;
            if (pending_curves.size() == 0) begin
               error_count++;
               $display("%0t unexpected response expected none actual %h", $time, rsp_pos_x);
            end else begin
               c = pending_curves.pop_front();
               check_field("pos_x", c.pos_x, rsp_pos_x);
               check_field("pos_y", c.pos_y, rsp_pos_y);
               check_field("pos_z", c.pos_z, rsp_pos_z);
               check_field("slope_x", c.slope_x, rsp_slope_x);
               check_field("slope_y", c.slope_y, rsp_slope_y);
               check_field("slope_z", c.slope_z, rsp_slope_z);
               check_field("clipped", c.clipped, rsp_clipped);
            end
         end
         if (stuck_cycles > 5000) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_request(input func_type f, input logic [IDX_W-1:0] idx,
                               input coord_type x, input coord_type y, input coord_type z,
                               input logic [T_W-1:0] g);
      point_type pt;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_point_index <= idx;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_eval_t <= g;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      if (f == FUNC_WRITE) begin
         pt.x = x; pt.y = y; pt.z = z;
         point_store[idx] = pt;
      end else begin
         pending_curves.insert(pending_curves.size(), blend_curve(g));
      end
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_curves.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_point_count(input logic [CNT_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      point_count = v;
   endtask

   function automatic coord_type random_coord;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return coord_type'($signed($urandom_range(32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   task automatic test_load_points;
      for (int i = 0; i < 64; i++)
         send_request(FUNC_WRITE, IDX_W'(i), random_coord(), random_coord(), random_coord(),
                      $urandom);
   endtask

   task automatic test_directed;
      send_request(FUNC_WRITE, 0, 32'sh80000000, 32'sh7fffffff, 0, 0);
      send_request(FUNC_WRITE, 1, 32'sh7fffffff, 32'sh80000000, 0, 0);
      send_request(FUNC_WRITE, 2, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
      send_request(FUNC_WRITE, 3, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
      set_point_count(7'd4);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h0000);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h2000);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h8000);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'hffff);
      set_point_count(7'd0);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h4000);
      set_point_count(7'd127);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'hffff);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h0400);
      set_point_count(7'd64);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h0000);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'hfbff);
      set_point_count(7'd3);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'h5555);
      set_point_count(7'd65);
      send_request(FUNC_EVAL, 0, 0, 0, 0, 16'haaaa);
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct, input int count);
      logic [CNT_W-1:0] cnt;
      send_idle_pct = tx_pct;
      recv_idle_pct = rx_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            case ($urandom_range(4))
               0: cnt = 7'd4;
               1: cnt = 7'd64;
               2: cnt = $urandom;
               default: cnt = $urandom_range(64, 4);
            endcase
            set_point_count(cnt);
         end
         if ($urandom_range(3) == 0)
            send_request(FUNC_WRITE, $urandom, random_coord(), random_coord(), random_coord(),
                         $urandom);
         else
            send_request(FUNC_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_start <= 1'b1;
      for (int i = 0; i < 60; i++)
         send_request(FUNC_EVAL, 0, 0, 0, 0, $urandom);
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_points();
      test_directed();
      test_random(34, 45, 280);
      test_random(45, 34, 280);
      test_random(0, 0, 280);
      test_backpressure();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
